/* design/onb_pkg.sv */
// Package for the orthonormal basis block: widths, the lane record and the default scale.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps

package onb_pkg;

  // Default fraction bits of the results (Q2.14)
  localparam int ONB_FRAC_BITS = 14;

  localparam int COMP_W = 16;  // width of one vector component on the ports
  localparam int SQ_W   = 64;  // squares and squared norms

  // One result component on its way into the normalizer
  typedef struct packed {
    logic            neg;  // sign of the component after the selected sign is applied
    logic [SQ_W-1:0] sq;   // component squared
    logic [SQ_W-1:0] nsq;  // squared norm of the whole vector
  } lane_in_t;

endpackage

/* design/onb_front.sv */
// Front end: pick the largest component, build u and w = a x u, and form squares and norms.
// Four register stages; uses onb_pkg.
`timescale 1ns / 1ps

module onb_front (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [15:0]          ax,
  input  logic signed [15:0]          ay,
  input  logic signed [15:0]          az,
  output onb_pkg::lane_in_t [5:0]     lanes,
  output logic                        deg
);

  typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_t;

  logic signed [16:0] e0, e1, e2;
  logic [16:0] m0, m1, m2;
  axis_t idx;
  logic signed [16:0] u0_c, u1_c, u2_c;
  logic sneg_c;

  assign e0 = 17'(ax);
  assign e1 = 17'(ay);
  assign e2 = 17'(az);
  assign m0 = e0[16] ? 17'(-e0) : e0;
  assign m1 = e1[16] ? 17'(-e1) : e1;
  assign m2 = e2[16] ? 17'(-e2) : e2;
  assign idx = (m0 < m1) ? ((m1 < m2) ? AXIS_Z : AXIS_Y) : ((m0 < m2) ? AXIS_Z : AXIS_X);

  always_comb begin
    case (idx)
      AXIS_Y: begin
        u0_c = e1;  u1_c = -e0;  u2_c = '0;  sneg_c = e1[16];
      end
      AXIS_Z: begin
        u0_c = e2;  u1_c = '0;  u2_c = -e0;  sneg_c = e2[16];
      end
      default: begin
        u0_c = -e1;  u1_c = e0;  u2_c = '0;  sneg_c = e0[16];
      end
    endcase
  end

  // stage 1: direction u
  logic signed [16:0] s1_a [3];
  logic signed [16:0] s1_u [3];
  logic s1_sneg, s1_deg;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a[0] <= e0;  s1_a[1] <= e1;  s1_a[2] <= e2;
      s1_u[0] <= u0_c;  s1_u[1] <= u1_c;  s1_u[2] <= u2_c;
      s1_sneg <= sneg_c;
      s1_deg  <= (m0 == '0) && (m1 == '0) && (m2 == '0);
    end
  end

  // stage 2: cross product and squares of u
  logic signed [34:0] w_c [3];
  logic signed [33:0] usq_c [3];
  logic signed [32:0] s2_w [3];
  logic [30:0] s2_usq [3];
  logic [2:0] s2_bneg;
  logic s2_sneg, s2_deg;

  assign w_c[0] = 35'(s1_a[1]) * 35'(s1_u[2]) - 35'(s1_a[2]) * 35'(s1_u[1]);
  assign w_c[1] = 35'(s1_a[2]) * 35'(s1_u[0]) - 35'(s1_a[0]) * 35'(s1_u[2]);
  assign w_c[2] = 35'(s1_a[0]) * 35'(s1_u[1]) - 35'(s1_a[1]) * 35'(s1_u[0]);

  for (genvar i = 0; i < 3; i++) begin : g_s2
    assign usq_c[i] = s1_u[i] * s1_u[i];
    always_ff @(posedge clk) begin
      if (en) begin
        s2_w[i]    <= 33'(w_c[i]);
        s2_usq[i]  <= 31'(usq_c[i]);
        s2_bneg[i] <= s1_u[i][16] ^ s1_sneg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sneg <= s1_sneg;
      s2_deg  <= s1_deg;
    end
  end

  // stage 3: squares of w
  logic signed [65:0] wsq_c [3];
  logic [63:0] s3_wsq [3];
  logic [30:0] s3_usq [3];
  logic [2:0] s3_bneg, s3_cneg;
  logic s3_deg;

  for (genvar i = 0; i < 3; i++) begin : g_s3
    assign wsq_c[i] = s2_w[i] * s2_w[i];
    always_ff @(posedge clk) begin
      if (en) begin
        s3_wsq[i]  <= 64'(wsq_c[i]);
        s3_usq[i]  <= s2_usq[i];
        s3_cneg[i] <= s2_w[i][32] ^ s2_sneg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_bneg <= s2_bneg;
      s3_deg  <= s2_deg;
    end
  end

  // stage 4: squared norms
  logic [63:0] nsq_u, nsq_w;
  assign nsq_u = 64'(s3_usq[0]) + 64'(s3_usq[1]) + 64'(s3_usq[2]);
  assign nsq_w = s3_wsq[0] + s3_wsq[1] + s3_wsq[2];

  for (genvar i = 0; i < 3; i++) begin : g_s4
    always_ff @(posedge clk) begin
      if (en) begin
        lanes[i].neg   <= s3_bneg[i];
        lanes[i].sq    <= 64'(s3_usq[i]);
        lanes[i].nsq   <= nsq_u;
        lanes[i+3].neg <= s3_cneg[i];
        lanes[i+3].sq  <= s3_wsq[i];
        lanes[i+3].nsq <= nsq_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg <= s3_deg;
    end
  end

endmodule

/* design/onb_div.sv */
// Pipelined restoring divider: quotient of sq * 4^(FRAC_BITS+1) by nsq, one bit per stage.
// Uses onb_pkg.
`timescale 1ns / 1ps

module onb_div #(
  parameter int FRAC_BITS = onb_pkg::ONB_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      en,
  input  onb_pkg::lane_in_t         din,
  output logic [2*FRAC_BITS+2:0]    quo,
  output logic                      neg
);

  localparam int QW = 2 * FRAC_BITS + 3;
  localparam int W  = onb_pkg::SQ_W;

  logic [W-1:0]  rem  [QW-1];
  logic [W-1:0]  den  [QW-1];
  logic [QW-1:0] qs   [QW];
  logic          negs [QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [W:0]    trial;
    logic [W-1:0]  dprev;
    logic [QW-1:0] qprev;
    logic          nprev;
    logic          ge;

    if (k == 0) begin : g_first
      assign trial = {1'b0, din.sq};
      assign dprev = din.nsq;
      assign qprev = '0;
      assign nprev = din.neg;
    end else begin : g_next
      assign trial = {rem[k-1], 1'b0};
      assign dprev = den[k-1];
      assign qprev = qs[k-1];
      assign nprev = negs[k-1];
    end

    assign ge = trial >= {1'b0, dprev};

    always_ff @(posedge clk) begin
      if (en) begin
        qs[k]   <= {qprev[QW-2:0], ge};
        negs[k] <= nprev;
      end
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= ge ? W'(trial - {1'b0, dprev}) : W'(trial);
          den[k] <= dprev;
        end
      end
    end
  end

  assign quo = qs[QW-1];
  assign neg = negs[QW-1];

endmodule

/* design/onb_sqrt.sv */
// Pipelined integer square root, two radicand bits per stage, then round, sign and saturate.
// Depends on the quotient format of onb_div; uses onb_pkg.
`timescale 1ns / 1ps

module onb_sqrt #(
  parameter int FRAC_BITS = onb_pkg::ONB_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [2*FRAC_BITS+2:0]    quo,
  input  logic                      neg,
  output logic signed [onb_pkg::COMP_W-1:0] res
);

  localparam int SW = FRAC_BITS + 2;
  localparam int RW = 2 * SW;

  logic [SW+1:0] rem  [SW-1];
  logic [RW-1:0] rad  [SW-1];
  logic [SW-1:0] root [SW];
  logic          negs [SW];

  for (genvar k = 0; k < SW; k++) begin : g_st
    logic [SW+1:0] rprev;
    logic [RW-1:0] dprev;
    logic [SW-1:0] oprev;
    logic          nprev;
    logic [SW+2:0] cur;
    logic [SW+2:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rprev = '0;
      assign dprev = RW'(quo);
      assign oprev = '0;
      assign nprev = neg;
    end else begin : g_next
      assign rprev = rem[k-1];
      assign dprev = rad[k-1];
      assign oprev = root[k-1];
      assign nprev = negs[k-1];
    end

    assign cur   = {rprev[SW:0], dprev[RW-1:RW-2]};
    assign trial = {1'b0, oprev, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root[k] <= {oprev[SW-2:0], ge};
        negs[k] <= nprev;
      end
    end

    if (k < SW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= ge ? (SW+2)'(cur - trial) : (SW+2)'(cur);
          rad[k] <= {dprev[RW-3:0], 2'b00};
        end
      end
    end
  end

  // round to nearest odd-step boundary, then sign and clamp to 16 bits
  logic [SW:0]  rsum;
  logic [32:0]  rmag;
  assign rsum = (SW+1)'(root[SW-1]) + (SW+1)'(1);
  assign rmag = 33'(rsum[SW:1]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (negs[SW-1]) begin
        res <= (rmag > 33'd32768) ? 16'sh8000 : 16'(-rmag);
      end else begin
        res <= (rmag > 33'd32767) ? 16'sh7fff : 16'(rmag);
      end
    end
  end

endmodule

/* design/orthonormal_basis_from_unit_vector.sv */
// Top level of the orthonormal basis block: front end, six divider and square-root lanes.
// Depends on onb_pkg, onb_front, onb_div and onb_sqrt.
`timescale 1ns / 1ps

// Takes one vector a = (ax, ay, az) per transaction and returns the unit vectors b and
// c = a x b that complete it to an orthonormal basis, each component rounded once to
// Q(FRAC_BITS) and clamped to 16 bits. The block accepts a new vector every cycle while
// the output is not stalled. The pipeline has four front-end stages, a 2*FRAC_BITS+3
// stage restoring divider, a FRAC_BITS+2 stage square root and one rounding stage. A zero
// vector gives all-zero components with the degenerate flag set. Backpressure on the
// output side freezes the whole pipeline; nothing is dropped or repeated.
module orthonormal_basis_from_unit_vector #(
  parameter int FRAC_BITS = onb_pkg::ONB_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // ax [15:0], ay [31:16], az [47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // bx, by, bz, cx, cy, cz, 16 bits each from bit 0 up
  output logic [0:0]  m_tuser    // degenerate [0]
);

  localparam int FRONT_LAT = 4;
  localparam int LANE_LAT  = 3 * FRAC_BITS + 6;
  localparam int LAT       = FRONT_LAT + LANE_LAT;

  // one enable for every stage: advance unless the output register holds an untaken result
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  onb_pkg::lane_in_t [5:0] lanes;
  logic front_deg;

  onb_front u_front (
    .clk   (clk),
    .en    (adv),
    .ax    (s_tdata[15:0]),
    .ay    (s_tdata[31:16]),
    .az    (s_tdata[47:32]),
    .lanes (lanes),
    .deg   (front_deg)
  );

  logic signed [15:0] comp [6];

  for (genvar i = 0; i < 6; i++) begin : g_lane
    logic [2*FRAC_BITS+2:0] quo;
    logic                   neg;

    onb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (adv),
      .din (lanes[i]),
      .quo (quo),
      .neg (neg)
    );

    onb_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
      .clk (clk),
      .en  (adv),
      .quo (quo),
      .neg (neg),
      .res (comp[i])
    );
  end

  // valid bits shadow the data stages; the degenerate flag rides beside the lanes
  logic [LAT-1:0]      vld;
  logic [LANE_LAT-1:0] degp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      degp <= {degp[LANE_LAT-2:0], front_deg};
    end
  end

  assign m_tvalid   = vld[LAT-1];
  assign m_tuser[0] = degp[LANE_LAT-1];

  // force zero output for a degenerate vector (the divider saw a zero norm)
  for (genvar i = 0; i < 6; i++) begin : g_out
    assign m_tdata[16*i +: 16] = degp[LANE_LAT-1] ? 16'h0000 : comp[i];
  end

  // a degenerate result carries only zeros
  a_deg_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 96'h0)
    else $error("degenerate result with nonzero components");

  // b always has a zero in y or z
  a_b_shape : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata[31:16] == 16'h0) || (m_tdata[47:32] == 16'h0))
    else $error("first basis vector has no zero component");

  // the input side stalls exactly when a finished result is held
  a_ready : assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready disagrees with output stall");

  // a held result keeps its valid bit through the stall
  a_hold : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tuser))
    else $error("held result dropped during stall");

endmodule

/* verif/orthonormal_basis_checker.sv */
// Scoreboard for the orthonormal basis block: watches both stream channels, predicts
// each result from the accepted vector and compares it field by field. Depends on onb_pkg.
`timescale 1ns / 1ps

module orthonormal_basis_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [95:0] m_tdata,
  input  logic [0:0]  m_tuser,
  output int          errors,
  output int          pending,
  output int          results_seen,
  output int          degenerate_seen
);
  localparam int FB = onb_pkg::ONB_FRAC_BITS;

  typedef struct {
    logic signed [15:0] comp [6];
    logic               degen;
  } basis_t;

  basis_t basis_q [$];

  // round(|v| * 2^FB / sqrt(nsq)) half away from zero, sign after rounding, clamp to 16 bits
  function automatic logic signed [15:0] unit_comp(longint v, longint unsigned nsq);
    bit [127:0] lhs, rhs;
    longint unsigned mag, lo, hi, mid, t;
    longint r;
    mag = (v < 0) ? -v : v;
    if (mag == 0 || nsq == 0) return 0;
    rhs = (128'(mag) * 128'(mag)) << (2 * FB + 2);
    lo = 0;
    hi = 64'd1 << FB;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      t = 2 * mid - 1;
      lhs = 128'(t) * 128'(t) * 128'(nsq);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    r = (v < 0) ? -longint'(lo) : longint'(lo);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic basis_t complete_basis(logic [47:0] d);
    basis_t res;
    longint a [3], m [3], u [3], w [3], s;
    longint unsigned nu, nw;
    int idx;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(d[16*i +: 16]));
      m[i] = (a[i] < 0) ? -a[i] : a[i];
    end
    // ties favor the lower index for x against y or z, and y against z
    idx = (m[0] < m[1]) ? ((m[1] < m[2]) ? 2 : 1) : ((m[0] < m[2]) ? 2 : 0);
    res.degen = (m[idx] == 0);
    for (int i = 0; i < 6; i++) res.comp[i] = 0;
    if (res.degen) return res;
    s = (a[idx] < 0) ? -1 : 1;
    case (idx)
      0: begin u[0] = -a[1]; u[1] = a[0];  u[2] = 0;     end
      1: begin u[0] = a[1];  u[1] = -a[0]; u[2] = 0;     end
      default: begin u[0] = a[2]; u[1] = 0; u[2] = -a[0]; end
    endcase
    w[0] = a[1] * u[2] - a[2] * u[1];
    w[1] = a[2] * u[0] - a[0] * u[2];
    w[2] = a[0] * u[1] - a[1] * u[0];
    nu = 0;
    nw = 0;
    for (int i = 0; i < 3; i++) begin
      nu += longint'(u[i] * u[i]);
      nw += longint'(w[i] * w[i]);
    end
    for (int i = 0; i < 3; i++) begin
      res.comp[i]     = unit_comp(s * u[i], nu);
      res.comp[i + 3] = unit_comp(s * w[i], nw);
    end
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
  endtask

  initial begin
    errors = 0;
    results_seen = 0;
    degenerate_seen = 0;
  end

  assign pending = basis_q.size();

  always @(posedge clk) begin
    basis_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) basis_q.push_back(complete_basis(s_tdata));
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (basis_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          want = basis_q.pop_front();
          if (want.degen) degenerate_seen++;
          for (int i = 0; i < 6; i++)
            if ($signed(m_tdata[16*i +: 16]) !== want.comp[i])
              report($sformatf("component %0d", i), $signed(m_tdata[16*i +: 16]),
                     want.comp[i]);
          if (m_tuser[0] !== want.degen) report("degenerate", m_tuser[0], want.degen);
        end
      end
    end
  end
endmodule

/* verif/orthonormal_basis_from_unit_vector_tb.sv */
// Testbench top for orthonormal_basis_from_unit_vector: clock, reset, stimulus, verdict.
// Depends on onb_pkg, the block itself and orthonormal_basis_checker.
`timescale 1ns / 1ps

module orthonormal_basis_from_unit_vector_tb;
  localparam int LIMIT  = 600000;  // generous cycle budget for the whole run
  localparam int DRAIN  = 80;      // idle clocks after the checker queue empties, before the verdict

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [95:0] m_tdata;
  logic [0:0]  m_tuser;

  int errors, pending, results_seen, degenerate_seen;
  int cycles = 0;
  int long_hold_req = 0;  // set by the stimulus to make the receiver hold off

  always #1 clk = ~clk;

  orthonormal_basis_from_unit_vector uut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  orthonormal_basis_checker chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .errors, .pending, .results_seen, .degenerate_seen
  );

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // Watchdog: end the run if it takes far too long
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("orthonormal_basis_from_unit_vector_tb: errors");
      $finish;
    end
  end

  // Receiver: random stalls, free-running stretches, and one long hold-off on request
  initial begin
    int hold;
    int phase;
    hold = 0;
    phase = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold_req != 0) begin
        long_hold_req = 0;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 0;
      end else begin
        phase = (phase + 1) % 400;
        if (phase < 100) m_tready <= 1;  // stretch with no stalls
        else if ($urandom_range(0, 3) == 0) begin
          m_tready <= 0;
          hold = gap_len();
        end else m_tready <= 1;
      end
    end
  end

  // Offer one vector and hold it until accepted, then, if gaps is set, idle for a random gap
  task automatic send_vec(logic [15:0] x, logic [15:0] y, logic [15:0] z, bit gaps);
    int g;
    s_tvalid <= 1;
    s_tdata  <= {z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Random components within +-16384 each, with occasional raw 16-bit noise or tiny values
  task automatic send_random();
    logic [15:0] c [3];
    int k;
    k = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      if (k == 0) c[i] = 16'($urandom);
      else if (k == 1) c[i] = 16'(int'($urandom_range(0, 8)) - 4);
      else c[i] = 16'(int'($urandom_range(0, 32768)) - 16384);
    end
    // force ties in magnitude now and then
    if (k == 2) c[1] = ($urandom_range(0, 1) != 0) ? c[0] : -c[0];
    if (k == 3) c[2] = ($urandom_range(0, 1) != 0) ? c[1] : -c[1];
    send_vec(c[0], c[1], c[2], 1);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: zero vector, axes at both signs, extremes of the field, ties
    send_vec(16'sd0, 16'sd0, 16'sd0, 0);
    send_vec(16'sd16384, 16'sd0, 16'sd0, 0);
    send_vec(-16'sd16384, 16'sd0, 16'sd0, 0);
    send_vec(16'sd0, 16'sd16384, 16'sd0, 0);
    send_vec(16'sd0, -16'sd16384, 16'sd0, 0);
    send_vec(16'sd0, 16'sd0, 16'sd16384, 0);
    send_vec(16'sd0, 16'sd0, -16'sd16384, 0);
    send_vec(16'sd9459, 16'sd9459, 16'sd9459, 0);       // three-way tie picks x
    send_vec(16'sd0, -16'sd11585, 16'sd11585, 0);       // y against z tie picks y
    send_vec(-16'sd11585, 16'sd0, 16'sd11585, 0);       // x against z tie picks x
    send_vec(16'sd11585, -16'sd11585, 16'sd0, 0);       // x against y tie picks x
    send_vec(16'h8000, 16'h8000, 16'h8000, 0);          // most negative, not unit length
    send_vec(16'h7fff, 16'h7fff, 16'h7fff, 0);
    send_vec(16'h8000, 16'h7fff, 16'h0001, 0);
    send_vec(16'hffff, 16'hffff, 16'hffff, 0);
    send_vec(16'h5555, 16'haaaa, 16'h5555, 0);
    send_vec(16'haaaa, 16'h5555, 16'haaaa, 0);
    send_vec(16'h0001, 16'h0000, 16'h0000, 0);          // tiny but nonzero
    send_vec(16'h0000, 16'hffff, 16'h0000, 0);
    send_vec(16'sd1, 16'sd2, 16'sd3, 1);

    // Random phase: halfway through, pause until drained, then provoke a long hold-off
    for (int n = 0; n < 1600; n++) begin
      if (n == 800) begin
        s_tvalid <= 0;
        // let the checker record the last accepted vector before testing the count
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        long_hold_req = 1;
      end
      send_random();
    end
    s_tvalid <= 0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d results, %0d of them degenerate, with stalls and a long hold-off",
             results_seen, degenerate_seen);
    if (pending != 0) $display("%0d results never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("orthonormal_basis_from_unit_vector_tb: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("orthonormal_basis_from_unit_vector_tb: errors");
    end
    $finish;
  end
endmodule
